// ===== rtl/core/piecewise_linear_table_lookup_core_defines.svh =====
// Assertion macros used by the checker of the table lookup core.
`ifndef PIECEWISE_LINEAR_TABLE_LOOKUP_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_LOOKUP_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define PLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("table lookup core: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define PLT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("table lookup core: same-cycle check failed");

// Checked also while reset is applied.
`define PLT_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("table lookup core: reset check failed");

`endif

// ===== rtl/core/plt_pkg.sv =====
// Shared constants for the piecewise-linear table lookup core.
`default_nettype none
package plt_pkg;
    localparam int DATA_W = 32;
    localparam int TOL_W  = 16;
    localparam int SLOT_W = 4;
    localparam int ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/core/piecewise_linear_table_lookup_core.sv =====
// Piecewise-linear table lookup core: slot store, nearest-key scan and interpolation.
//
// Input words arrive on the s_ channel (valid/ready) and carry an action: write a slot,
// remove a slot, or query. Writes and removes return no word. A query returns exactly
// one word on the m_ channel (valid/ready). A query scans every slot one per cycle
// through the key and result memories, using only the used ones; then, when it has
// to interpolate, runs a shift-add multiplier, a restoring divider and a final step
// to add and saturate. A query without a query value goes straight to the final state.
// s_ready is high only while the core is idle; one word is worked on at a time.
// The result sits in an output register; a stalled receiver holds the core in its
// final state until the previous word is taken, and writes wait meanwhile.
// cfg_wr_en writes the match tolerance, with no handshake.
// Synchronous active-low reset clears the used and result-valid flags, the tolerance
// and the control state; key and result memories keep whatever they hold.
`default_nettype none
module piecewise_linear_table_lookup_core
    import plt_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [TOL_W-1:0]         cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [ACT_W-1:0]         s_action,
    input  wire logic [SLOT_W-1:0]        s_slot,
    input  wire logic signed [DATA_W-1:0] s_key_value,
    input  wire logic signed [DATA_W-1:0] s_entry_result,
    input  wire logic                     s_entry_result_valid,
    input  wire logic                     s_query_valid,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_result_value,
    output logic                          m_result_valid
);
    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int SEXT_W = 9;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [DATA_W-1:0] key_mem [TABLE_SLOTS];
    logic [DATA_W-1:0] res_mem [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] used_reg, used_next;
    logic [TABLE_SLOTS-1:0] rok_reg, rok_next;
    logic [TOL_W-1:0]       tol_reg;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rdv_reg, rdv_next;
    logic [IDX_W-1:0] rdi_reg, rdi_next;
    logic [DATA_W-1:0] rd_key_reg, rd_res_reg;
    logic [4:0]       step_reg, step_next;

    logic signed [DATA_W-1:0] q_reg, q_next;
    logic hit_f_reg, hit_f_next, lo_f_reg, lo_f_next, hi_f_reg, hi_f_next;
    logic hit_ok_reg, hit_ok_next, lo_ok_reg, lo_ok_next, hi_ok_reg, hi_ok_next;
    logic signed [DATA_W-1:0] hit_key_reg, hit_key_next, lo_key_reg, lo_key_next;
    logic signed [DATA_W-1:0] hi_key_reg, hi_key_next;
    logic signed [DATA_W-1:0] hit_res_reg, hit_res_next, lo_res_reg, lo_res_next;
    logic signed [DATA_W-1:0] hi_res_reg, hi_res_next;

    logic [DATA_W-1:0]   mplr_reg, mplr_next;
    logic [2*DATA_W-1:0] mcand_reg, mcand_next;
    logic [2*DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0]   dk_reg, dk_next;
    logic                neg_reg, neg_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   quo_reg, quo_next;

    logic signed [DATA_W-1:0] ans_reg, ans_next;
    logic ok_reg, ok_next;

    logic m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;
    logic m_rvalid_reg, m_rvalid_next;

    logic [SEXT_W-1:0] slot_ext;
    logic              slot_in_range;
    logic [IDX_W-1:0]  slot_idx;
    logic              in_fire;
    logic              mem_we;
    logic [IDX_W-1:0]  rd_addr;

    logic signed [DATA_W:0]   scan_d, tol_s;
    logic signed [DATA_W-1:0] rk;
    logic                     r_used, in_tol, is_lo, is_hi;
    logic signed [DATA_W:0]   setup_dq, setup_dr, setup_dk;
    logic [DATA_W-1:0]        setup_mag;
    logic [DATA_W:0]          rem_sh, rem_sub;
    logic signed [DATA_W+1:0] sq, sum_full;

    assign slot_ext      = SEXT_W'(s_slot);
    assign slot_in_range = slot_ext < SEXT_W'(TABLE_SLOTS);
    assign slot_idx      = slot_ext[IDX_W-1:0];
    assign in_fire       = s_valid && s_ready;
    assign mem_we        = in_fire && (s_action == ACT_WRITE) && slot_in_range;
    assign rd_addr       = cnt_reg[IDX_W-1:0];

    // Key and result memories: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[slot_idx] <= s_key_value;
            res_mem[slot_idx] <= s_entry_result;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_res_reg <= res_mem[rd_addr];
    end

    always_comb begin
        rk     = $signed(rd_key_reg);
        r_used = used_reg[rdi_reg];
        scan_d = {rk[DATA_W-1], rk} - {q_reg[DATA_W-1], q_reg};
        tol_s  = $signed({{(DATA_W+1-TOL_W){1'b0}}, tol_reg});
        in_tol = r_used && (scan_d <= tol_s) && (scan_d >= -tol_s);
        is_lo  = r_used && (rk <= q_reg) && (!lo_f_reg || rk > lo_key_reg);
        is_hi  = r_used && (rk >= q_reg) && (!hi_f_reg || rk < hi_key_reg);

        setup_dq  = {q_reg[DATA_W-1], q_reg} - {lo_key_reg[DATA_W-1], lo_key_reg};
        setup_dr  = {hi_res_reg[DATA_W-1], hi_res_reg}
                  - {lo_res_reg[DATA_W-1], lo_res_reg};
        setup_dk  = {hi_key_reg[DATA_W-1], hi_key_reg}
                  - {lo_key_reg[DATA_W-1], lo_key_reg};
        setup_mag = setup_dr[DATA_W] ? DATA_W'(-setup_dr) : setup_dr[DATA_W-1:0];

        rem_sh  = {rem_reg, prod_reg[2*DATA_W-1]};
        rem_sub = rem_sh - {1'b0, dk_reg};

        sq       = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        sum_full = {{2{lo_res_reg[DATA_W-1]}}, lo_res_reg} + sq;
    end

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        rok_next     = rok_reg;
        cnt_next     = cnt_reg;
        rdv_next     = 1'b0;
        rdi_next     = rd_addr;
        step_next    = step_reg;
        q_next       = q_reg;
        hit_f_next   = hit_f_reg;
        lo_f_next    = lo_f_reg;
        hi_f_next    = hi_f_reg;
        hit_ok_next  = hit_ok_reg;
        lo_ok_next   = lo_ok_reg;
        hi_ok_next   = hi_ok_reg;
        hit_key_next = hit_key_reg;
        lo_key_next  = lo_key_reg;
        hi_key_next  = hi_key_reg;
        hit_res_next = hit_res_reg;
        lo_res_next  = lo_res_reg;
        hi_res_next  = hi_res_reg;
        mplr_next    = mplr_reg;
        mcand_next   = mcand_reg;
        prod_next    = prod_reg;
        dk_next      = dk_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        ans_next     = ans_reg;
        ok_next      = ok_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_rvalid_next = m_rvalid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_action)
                        ACT_WRITE: begin
                            if (slot_in_range) begin
                                used_next[slot_idx] = 1'b1;
                                rok_next[slot_idx]  = s_entry_result_valid;
                            end
                        end
                        ACT_REMOVE: begin
                            if (slot_in_range) begin
                                used_next[slot_idx] = 1'b0;
                            end
                        end
                        ACT_QUERY: begin
                            q_next     = s_key_value;
                            hit_f_next = 1'b0;
                            lo_f_next  = 1'b0;
                            hi_f_next  = 1'b0;
                            cnt_next   = '0;
                            ok_next    = 1'b0;
                            ans_next   = '0;
                            state_next = s_query_valid ? ST_SCAN : ST_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (cnt_reg < CNT_W'(TABLE_SLOTS)) begin
                    rdv_next = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rdv_reg) begin
                    // Strict compares keep the lowest slot among equal keys.
                    if (in_tol && (!hit_f_reg || rk < hit_key_reg)) begin
                        hit_f_next   = 1'b1;
                        hit_key_next = rk;
                        hit_res_next = $signed(rd_res_reg);
                        hit_ok_next  = rok_reg[rdi_reg];
                    end
                    if (is_lo) begin
                        lo_f_next   = 1'b1;
                        lo_key_next = rk;
                        lo_res_next = $signed(rd_res_reg);
                        lo_ok_next  = rok_reg[rdi_reg];
                    end
                    if (is_hi) begin
                        hi_f_next   = 1'b1;
                        hi_key_next = rk;
                        hi_res_next = $signed(rd_res_reg);
                        hi_ok_next  = rok_reg[rdi_reg];
                    end
                end else if (cnt_reg == CNT_W'(TABLE_SLOTS)) begin
                    state_next = ST_DONE;
                    if (hit_f_reg) begin
                        ok_next  = hit_ok_reg;
                        ans_next = hit_ok_reg ? hit_res_reg : '0;
                    end else if (lo_f_reg && hi_f_reg && lo_ok_reg && hi_ok_reg) begin
                        ok_next = 1'b1;
                        if (lo_res_reg == hi_res_reg) begin
                            ans_next = hi_res_reg;
                        end else begin
                            // Without a match the query lies strictly between the keys.
                            mplr_next  = setup_dq[DATA_W-1:0];
                            mcand_next = {{DATA_W{1'b0}}, setup_mag};
                            prod_next  = '0;
                            dk_next    = setup_dk[DATA_W-1:0];
                            neg_next   = setup_dr[DATA_W];
                            step_next  = '0;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                if (mplr_reg[0]) begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[2*DATA_W-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[DATA_W-1:1]};
                step_next  = step_reg + 1'b1;
                if (step_reg == 5'd31) begin
                    // The quotient stays below 2^32, so the upper half is below dk.
                    rem_next   = prod_next[2*DATA_W-1:DATA_W];
                    prod_next  = {prod_next[DATA_W-1:0], {DATA_W{1'b0}}};
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                prod_next = {prod_reg[2*DATA_W-2:0], 1'b0};
                if (!rem_sub[DATA_W]) begin
                    rem_next = rem_sub[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_full > $signed({3'b000, {(DATA_W-1){1'b1}}})) begin
                    ans_next = {1'b0, {(DATA_W-1){1'b1}}};
                end else if (sum_full < $signed({3'b111, {(DATA_W-1){1'b0}}})) begin
                    ans_next = {1'b1, {(DATA_W-1){1'b0}}};
                end else begin
                    ans_next = sum_full[DATA_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = ok_reg ? ans_reg : '0;
                    m_rvalid_next = ok_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            rok_reg     <= '0;
            tol_reg     <= '0;
            cnt_reg     <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            rok_reg     <= rok_next;
            cnt_reg     <= cnt_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rdi_reg      <= rdi_next;
        step_reg     <= step_next;
        q_reg        <= q_next;
        hit_f_reg    <= hit_f_next;
        lo_f_reg     <= lo_f_next;
        hi_f_reg     <= hi_f_next;
        hit_ok_reg   <= hit_ok_next;
        lo_ok_reg    <= lo_ok_next;
        hi_ok_reg    <= hi_ok_next;
        hit_key_reg  <= hit_key_next;
        lo_key_reg   <= lo_key_next;
        hi_key_reg   <= hi_key_next;
        hit_res_reg  <= hit_res_next;
        lo_res_reg   <= lo_res_next;
        hi_res_reg   <= hi_res_next;
        mplr_reg     <= mplr_next;
        mcand_reg    <= mcand_next;
        prod_reg     <= prod_next;
        dk_reg       <= dk_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        ans_reg      <= ans_next;
        ok_reg       <= ok_next;
        m_value_reg  <= m_value_next;
        m_rvalid_reg <= m_rvalid_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_result_valid = m_rvalid_reg;
endmodule
`default_nettype wire

// ===== rtl/core/plt_checker.sv =====
// Port-level checker for the table lookup core, bound to the top level.
`default_nettype none
`include "piecewise_linear_table_lookup_core_defines.svh"
module plt_checker
    import plt_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic [ACT_W-1:0]         s_action,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [DATA_W-1:0] m_result_value,
    input wire logic                     m_result_valid
);
    `PLT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)
    `PLT_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_result_value))
    `PLT_ASSERT_SAME(a_no_answer_zero, m_valid && !m_result_valid, m_result_value == '0)
    `PLT_ASSERT_NEXT(a_query_busy, s_valid && s_ready && s_action == ACT_QUERY, !s_ready)
    `PLT_ASSERT_RESET(a_reset_empty, !aresetn, !m_valid)
endmodule

bind piecewise_linear_table_lookup_core plt_checker u_plt_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the piecewise-linear table lookup core.
`default_nettype none
module tb;
    import plt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int STALL_LIMIT = 3000;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]         act;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] res;
        logic                     res_ok;
        logic                     q_ok;
        bit                       typed;   // expected answer given in the row
        logic signed [DATA_W-1:0] t_value;
        logic                     t_valid;
    } lookup_row_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     valid;
    } answer_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [TOL_W-1:0]         cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ACT_W-1:0]         s_action = ACT_WRITE;
    logic [SLOT_W-1:0]        s_slot = '0;
    logic signed [DATA_W-1:0] s_key_value = '0;
    logic signed [DATA_W-1:0] s_entry_result = '0;
    logic                     s_entry_result_valid = 1'b0;
    logic                     s_query_valid = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_result_value;
    logic                     m_result_valid;

    piecewise_linear_table_lookup_core #(.TABLE_SLOTS(SLOTS)) dut (.*);

    always #10 aclk = ~aclk;

    // Predictor state.
    logic signed [DATA_W-1:0] slot_key [SLOTS];
    logic signed [DATA_W-1:0] slot_res [SLOTS];
    logic                     slot_res_ok [SLOTS];
    logic                     slot_used [SLOTS];
    logic [TOL_W-1:0]         tolerance;

    answer_t answers_due[$];
    int      fail_count = 0;
    int      words_sent = 0;
    int      queries_sent = 0;
    int      answers_seen = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;

    function automatic answer_t lookup_answer(logic signed [DATA_W-1:0] qv_in, logic q_ok);
        answer_t a;
        int hit, lo, hi;
        longint q, k, d, kb, rb, ka, ra, dr, sq, r;
        longint unsigned dq, dk, mag, quo;
        a.value = '0;
        a.valid = 1'b0;
        hit = -1; lo = -1; hi = -1;
        q = qv_in;
        if (!q_ok) return a;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
                k = slot_key[i];
                d = (k > q) ? k - q : q - k;
                if (d <= longint'(tolerance) && (hit < 0 || k < longint'(slot_key[hit])))
                    hit = i;
                if (k <= q && (lo < 0 || k > longint'(slot_key[lo]))) lo = i;
                if (k >= q && (hi < 0 || k < longint'(slot_key[hi]))) hi = i;
            end
        end
        if (hit >= 0) begin
            if (slot_res_ok[hit]) begin
                a.valid = 1'b1;
                a.value = slot_res[hit];
            end
        end else if (lo >= 0 && hi >= 0 && slot_res_ok[lo] && slot_res_ok[hi]) begin
            a.valid = 1'b1;
            if (lo == hi || slot_res[lo] == slot_res[hi]) begin
                a.value = slot_res[hi];
            end else begin
                kb = slot_key[lo]; rb = slot_res[lo];
                ka = slot_key[hi]; ra = slot_res[hi];
                dq = longint'(q - kb);
                dk = longint'(ka - kb);
                dr = ra - rb;
                mag = (dr < 0) ? longint'(-dr) : longint'(dr);
                quo = (dq * mag) / dk;
                sq = (dr < 0) ? -longint'(quo) : longint'(quo);
                r = rb + sq;
                if (r > 64'sh7fffffff) r = 64'sh7fffffff;
                if (r < -64'sh80000000) r = -64'sh80000000;
                a.value = r[DATA_W-1:0];
            end
        end
        return a;
    endfunction

    // Updates the predictor for one accepted word and queues its answer, if any.
    task automatic predict_word(lookup_row_t w);
        answer_t a;
        case (w.act)
            ACT_WRITE: begin
                slot_key[w.slot] = w.key;
                slot_res[w.slot] = w.res;
                slot_res_ok[w.slot] = w.res_ok;
                slot_used[w.slot] = 1'b1;
            end
            ACT_REMOVE: slot_used[w.slot] = 1'b0;
            ACT_QUERY: begin
                a = lookup_answer(w.key, w.q_ok);
                if (w.typed && (a.value !== w.t_value || a.valid !== w.t_valid)) begin
                    $error("typed row disagrees with predictor: %h/%b vs %h/%b",
                           w.t_value, w.t_valid, a.value, a.valid);
                    fail_count++;
                end
                if (w.typed) begin
                    a.value = w.t_value;
                    a.valid = w.t_valid;
                end
                answers_due = {answers_due, a};
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    // Drives one word, with random bursts and gaps, and waits for acceptance.
    task automatic send_word(lookup_row_t w);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 20);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 25);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_action <= w.act;
        s_slot <= w.slot;
        s_key_value <= w.key;
        s_entry_result <= w.res;
        s_entry_result_valid <= w.res_ok;
        s_query_valid <= w.q_ok;
        do @(posedge aclk); while (!s_ready);
        predict_word(w);
        words_sent++;
    endtask

    task automatic drain_answers();
        while (answers_due.size() != 0) @(posedge aclk);
    endtask

    // Tolerance is written only with the core idle.
    task automatic set_tolerance(logic [TOL_W-1:0] t);
        s_valid <= 1'b0;
        drain_answers();
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= t;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tolerance = t;
        burst_left = 0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            2:       return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            3:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return (int'($urandom_range(0, 64)) - 32) <<< 12;
        endcase
    endfunction

    function automatic lookup_row_t random_word();
        lookup_row_t w;
        int r;
        r = $urandom_range(0, 99);
        w.act = (r < 35) ? ACT_WRITE : (r < 45) ? ACT_REMOVE : (r < 96) ? ACT_QUERY : ACT_NONE;
        w.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        w.key = pick_key();
        w.res = ($urandom_range(0, 3) == 0) ? (int'($urandom_range(0, 8)) - 4) <<< 16
                                            : $urandom();
        w.res_ok = ($urandom_range(0, 9) != 0);
        w.q_ok = ($urandom_range(0, 9) != 0);
        w.typed = 1'b0;
        w.t_value = '0;
        w.t_valid = 1'b0;
        return w;
    endfunction

    // Receiver stall pattern: the mode is redrawn whenever its random countdown runs out.
    int ready_mode = 0;
    int mode_left = 0;
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(10, 60);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 0);
            2:       m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (mode_left % 8 < 5);
        endcase
    end

    // Answer checker.
    answer_t exp_a;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
                $error("answer word with nothing expected: %h/%b",
                       m_result_value, m_result_valid);
                fail_count++;
            end else begin
                exp_a = answers_due.pop_front();
                if (m_result_value !== exp_a.value) begin
                    $error("result_value expected %h actual %h", exp_a.value, m_result_value);
                    fail_count++;
                end
                if (m_result_valid !== exp_a.valid) begin
                    $error("result_valid expected %b actual %b", exp_a.valid, m_result_valid);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: timeout with %0d answers outstanding", answers_due.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic lookup_row_t row(logic [ACT_W-1:0] act, int slot, logic [31:0] key,
                                        logic [31:0] res, bit res_ok, bit q_ok,
                                        bit typed = 0, logic [31:0] tv = 0, bit tvalid = 0);
        lookup_row_t w;
        w.act = act; w.slot = SLOT_W'(slot); w.key = key; w.res = res;
        w.res_ok = res_ok; w.q_ok = q_ok;
        w.typed = typed; w.t_value = tv; w.t_valid = tvalid;
        return w;
    endfunction

    lookup_row_t directed[$];
    logic [TOL_W-1:0] phase_tol[5] = '{16'd0, 16'hffff, 16'd1, 16'h0100, 16'h2000};

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_res_ok[i] = 1'b0;
            slot_key[i] = '0;
            slot_res[i] = '0;
        end
        tolerance = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table, missing query, single entry, holes, invalid results, extremes.
        directed = '{
            row(ACT_QUERY,  0, 32'h0,        32'h0,        1, 1, 1, 32'h0, 0),
            row(ACT_QUERY,  0, 32'hffffffff, 32'hffffffff, 1, 0, 1, 32'h0, 0),
            row(ACT_WRITE,  0, 32'h00010000, 32'd100,      1, 0),
            row(ACT_QUERY,  7, 32'h00010000, 32'h0,        0, 1, 1, 32'd100, 1),
            row(ACT_QUERY,  0, 32'h00008000, 32'h0,        0, 1, 1, 32'h0, 0),
            row(ACT_QUERY,  0, 32'h00018000, 32'h0,        0, 1, 1, 32'h0, 0),
            row(ACT_WRITE, 15, 32'h00030000, -32'sd200,    1, 1),
            row(ACT_QUERY,  0, 32'h00020000, 32'h0,        0, 1),
            row(ACT_WRITE,  5, 32'h00020000, 32'd7,        0, 0),
            row(ACT_QUERY,  0, 32'h00020000, 32'h0,        0, 1, 1, 32'h0, 0),
            row(ACT_QUERY,  0, 32'h00018000, 32'h0,        0, 1, 1, 32'h0, 0),
            row(ACT_REMOVE, 5, 32'h0,        32'h0,        0, 0),
            row(ACT_REMOVE, 5, 32'hffffffff, 32'hffffffff, 1, 1),
            row(ACT_NONE,   9, 32'h12345678, 32'h0,        1, 1),
            row(ACT_QUERY,  0, 32'h00028000, 32'h0,        0, 1),
            row(ACT_WRITE,  6, 32'h00040000, -32'sd200,    1, 0),
            row(ACT_QUERY,  0, 32'h00038000, 32'h0,        0, 1, 1, -32'sd200, 1),
            row(ACT_WRITE,  2, 32'h00010000, 32'd555,      1, 0),
            row(ACT_QUERY,  0, 32'h00010000, 32'h0,        0, 1, 1, 32'd100, 1),
            row(ACT_WRITE,  3, 32'h80000000, 32'h7fffffff, 1, 0),
            row(ACT_WRITE,  4, 32'h7fffffff, 32'h80000000, 1, 0),
            row(ACT_QUERY,  0, 32'h7fffffff, 32'h0,        0, 1, 1, 32'h80000000, 1),
            row(ACT_QUERY,  0, 32'h80000000, 32'h0,        0, 1, 1, 32'h7fffffff, 1),
            row(ACT_QUERY,  0, 32'hc0000000, 32'h0,        0, 1),
            row(ACT_QUERY,  0, 32'h40000000, 32'h0,        0, 1)
        };
        set_tolerance(16'd0);
        foreach (directed[i]) send_word(directed[i]);

        for (int p = 0; p < 5; p++) begin
            set_tolerance(phase_tol[p]);
            for (int n = 0; n < 190; n++) begin
                if (p == 2 && n == 95) begin
                    // Hold the sender off until every answer is back.
                    s_valid <= 1'b0;
                    drain_answers();
                    burst_left = 0;
                end
                send_word(random_word());
            end
        end

        s_valid <= 1'b0;
        drain_answers();
        repeat (100) @(posedge aclk);
        $display("tb: %0d words sent, %0d queries, %0d answers checked", words_sent,
                 queries_sent, answers_seen);
        $display("tb: covered writes, removes, ignored words and 5 tolerance settings");
        if (fail_count == 0 && answers_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
